>>> rtl/rdsc_pkg.sv
package rdsc_pkg;

  localparam int ACC_WIDTH_DEF      = 32;
  localparam int MAX_OUT_DIGITS_DEF = 32;

  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RADIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RADIX = 1'd1;

  localparam logic [RADIX_W-1:0] SOURCE_RADIX_RST = 6'd10;
  localparam logic [RADIX_W-1:0] TARGET_RADIX_RST = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN        = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX        = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_EMIT
  } rdsc_state_t;

  typedef struct packed {
    logic               ok;
    logic [RADIX_W-1:0] value;
  } digit_val_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    else res = r;
    return res;
  endfunction

  function automatic digit_val_t char_value(logic [CHAR_W-1:0] c);
    digit_val_t  res;
    logic [CHAR_W-1:0] diff;
    res.ok    = 1'b0;
    res.value = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff      = c - CHAR_ZERO;
      res.ok    = 1'b1;
      res.value = diff[RADIX_W-1:0];
    end else if (c >= CHAR_A && c <= CHAR_Z) begin
      diff      = c - CHAR_A;
      res.ok    = 1'b1;
      res.value = diff[RADIX_W-1:0] + DECIMAL_DIGITS;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] value_char(logic [RADIX_W-1:0] v);
    logic [CHAR_W-1:0] res;
    if (v < DECIMAL_DIGITS) res = CHAR_ZERO + {2'b00, v};
    else res = CHAR_A + {2'b00, v - DECIMAL_DIGITS};
    return res;
  endfunction

endpackage

>>> rtl/rdsc_if.sv
interface rdsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

interface rdsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_out;
  logic       overflow;
  logic       bad_digit;

  modport source (output valid, output out_char, output last_out, output overflow,
                  output bad_digit, input ready);
  modport sink   (input valid, input out_char, input last_out, input overflow,
                  input bad_digit, output ready);
endinterface

>>> rtl/radix_digit_string_converter.sv
// Each input word is captured, then folded into the accumulator by one multiply-add.
// A word marked last then runs a restoring divider, ACC_WIDTH bit steps plus one
// store per result digit, and emits the digits, each with a digit memory read and
// then an output, when the sink is ready. Input is not ready from capture until
// the multiply-add ends, or for a last word until the final digit is taken.
// rst is synchronous: radices to 10 and 16, accumulator and flags to zero.
module radix_digit_string_converter
  import rdsc_pkg::*;
#(
  parameter int ACC_WIDTH      = ACC_WIDTH_DEF,
  parameter int MAX_OUT_DIGITS = MAX_OUT_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RADIX_W-1:0]   cfg_data,
  rdsc_in_if.sink              in_ch,
  rdsc_out_if.source           out_ch
);

  localparam int PROD_W = ACC_WIDTH + RADIX_W;
  localparam int BIT_W  = $clog2(ACC_WIDTH);
  localparam int CNT_W  = $clog2(MAX_OUT_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_OUT_DIGITS);

  rdsc_state_t state, state_next;

  logic [RADIX_W-1:0]   src_radix;
  logic [RADIX_W-1:0]   tgt_radix;
  logic [CHAR_W-1:0]    char_reg;
  logic                 last_reg;
  logic [ACC_WIDTH-1:0] acc;
  logic                 ovf_seen;
  logic                 bad_seen;
  logic [ACC_WIDTH-1:0] quo;
  logic [RADIX_W-1:0]   rem;
  logic [BIT_W-1:0]     bit_cnt;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     emit_idx;
  logic [RADIX_W-1:0]   rd_data;
  logic [RADIX_W-1:0]   digit_mem [MAX_OUT_DIGITS];

  logic [RADIX_W-1:0]   sr;
  logic [RADIX_W-1:0]   tr;
  digit_val_t           dv;
  logic                 digit_ok;
  logic [PROD_W-1:0]    mac_sum;
  logic                 mac_wrap;
  logic [ACC_WIDTH-1:0] acc_mac;
  logic [RADIX_W:0]     rem_shift;
  logic                 rem_ge;
  logic [RADIX_W:0]     rem_new;
  logic                 div_done;
  logic                 can_store;
  logic                 out_take;

  assign sr       = clamp_radix(src_radix);
  assign tr       = clamp_radix(tgt_radix);
  assign dv       = char_value(char_reg);
  assign digit_ok = dv.ok && (dv.value < sr);
  assign mac_sum  = PROD_W'(acc) * PROD_W'(sr) + PROD_W'(dv.value);
  assign mac_wrap = |mac_sum[PROD_W-1:ACC_WIDTH];
  assign acc_mac  = digit_ok ? mac_sum[ACC_WIDTH-1:0] : acc;

  assign rem_shift = {rem, quo[ACC_WIDTH-1]};
  assign rem_ge    = rem_shift >= {1'b0, tr};
  assign rem_new   = rem_ge ? rem_shift - {1'b0, tr} : rem_shift;
  assign div_done  = bit_cnt == BIT_W'(ACC_WIDTH - 1);
  assign can_store = count < CNT_W'(MAX_OUT_DIGITS);
  assign out_take  = (state == ST_EMIT) && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_radix <= SOURCE_RADIX_RST;
      tgt_radix <= TARGET_RADIX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_RADIX: src_radix <= cfg_data;
        REG_TARGET_RADIX: tgt_radix <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_ch.valid) state_next = ST_MAC;
      ST_MAC:   state_next = last_reg ? ST_DIV : ST_IDLE;
      ST_DIV:   if (div_done) state_next = ST_STORE;
      ST_STORE: state_next = (quo != '0) ? ST_DIV : ST_READ;
      ST_READ:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_ch.ready) state_next = (emit_idx == '0) ? ST_IDLE : ST_READ;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready      = state == ST_IDLE;
    out_ch.valid     = state == ST_EMIT;
    out_ch.out_char  = value_char(rd_data);
    out_ch.last_out  = emit_idx == '0;
    out_ch.overflow  = ovf_seen;
    out_ch.bad_digit = bad_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      ovf_seen <= 1'b0;
      bad_seen <= 1'b0;
    end else begin
      if (state == ST_MAC) begin
        acc <= acc_mac;
        if (digit_ok && mac_wrap) ovf_seen <= 1'b1;
        if (!digit_ok) bad_seen <= 1'b1;
      end
      if (state == ST_STORE && !can_store) ovf_seen <= 1'b1;
      if (out_take && emit_idx == '0) begin
        acc      <= '0;
        ovf_seen <= 1'b0;
        bad_seen <= 1'b0;
      end
    end
  end

  // capture, divider and emit datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        char_reg <= in_ch.digit_char;
        last_reg <= in_ch.last_digit;
      end
      ST_MAC: begin
        quo     <= acc_mac;
        rem     <= '0;
        bit_cnt <= '0;
        count   <= '0;
      end
      ST_DIV: begin
        quo     <= {quo[ACC_WIDTH-2:0], rem_ge};
        rem     <= rem_new[RADIX_W-1:0];
        bit_cnt <= bit_cnt + 1'b1;
      end
      ST_STORE: begin
        rem     <= '0;
        bit_cnt <= '0;
        if (can_store) count <= count + 1'b1;
        emit_idx <= can_store ? count[IDX_W-1:0] : IDX_W'(MAX_OUT_DIGITS - 1);
      end
      ST_READ: begin
      end
      ST_EMIT: begin
        if (out_ch.ready && emit_idx != '0) emit_idx <= emit_idx - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_STORE && can_store) digit_mem[count[IDX_W-1:0]] <= rem;
    if (state == ST_READ) rd_data <= digit_mem[emit_idx];
  end

endmodule

>>> rtl/rdsc_checker.sv
module rdsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_out,
  input logic       overflow,
  input logic       bad_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_out)
      && $stable(overflow) && $stable(bad_digit))
    else $error("output word changed while stalled");

  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a result is shown");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_out |=> !out_valid)
    else $error("output still valid after final digit");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_out |=> !in_ready && !(in_valid && in_ready))
    else $error("input taken in the middle of an emission");

  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .last_out  (out_ch.last_out),
  .overflow  (out_ch.overflow),
  .bad_digit (out_ch.bad_digit)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rdsc_pkg::*;

  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = ACC_WIDTH_DEF + 4;
  localparam int ITEM_TARGET   = 310;
  localparam int CALM_AFTER    = 270;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_out;
    logic              overflow;
    logic              bad_digit;
  } result_word_t;

  class conversion_checker;
    logic [RADIX_W-1:0]       src_reg;
    logic [RADIX_W-1:0]       dst_reg;
    logic [ACC_WIDTH_DEF-1:0] acc;
    bit                       wrapped;
    bit                       skipped;
    result_word_t             expected_chars[$];
    int unsigned              mismatches;

    function new();
      src_reg    = SOURCE_RADIX_RST;
      dst_reg    = TARGET_RADIX_RST;
      acc        = '0;
      wrapped    = 1'b0;
      skipped    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [RADIX_W-1:0] val);
      if (idx == REG_SOURCE_RADIX) src_reg = val;
      else if (idx == REG_TARGET_RADIX) dst_reg = val;
    endfunction

    function logic [RADIX_W-1:0] sat_radix(logic [RADIX_W-1:0] r);
      if (r < RADIX_MIN) return RADIX_MIN;
      if (r > RADIX_MAX) return RADIX_MAX;
      return r;
    endfunction

    // -1 for anything outside 0-9 / A-Z
    function int digit_of(logic [CHAR_W-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_A && c <= CHAR_Z) return int'(c - CHAR_A) + int'(DECIMAL_DIGITS);
      return -1;
    endfunction

    function logic [CHAR_W-1:0] to_char(int unsigned v);
      if (v < DECIMAL_DIGITS) return CHAR_W'(CHAR_ZERO + v);
      return CHAR_W'(CHAR_A + v - DECIMAL_DIGITS);
    endfunction

    function void load_char(logic [CHAR_W-1:0] c, logic fin);
      int                         v;
      logic [RADIX_W-1:0]         sr;
      logic [RADIX_W-1:0]         tr;
      logic [2*ACC_WIDTH_DEF-1:0] wide;
      logic [ACC_WIDTH_DEF-1:0]   num;
      int unsigned                rems[$];
      result_word_t               w;
      sr = sat_radix(src_reg);
      tr = sat_radix(dst_reg);
      v  = digit_of(c);
      if (v < 0 || v >= int'(sr)) begin
        skipped = 1'b1;
      end else begin
        wide = {{ACC_WIDTH_DEF{1'b0}}, acc} * sr + (2*ACC_WIDTH_DEF)'(v);
        if (wide[2*ACC_WIDTH_DEF-1:ACC_WIDTH_DEF] != '0) wrapped = 1'b1;
        acc = wide[ACC_WIDTH_DEF-1:0];
      end
      if (!fin) return;
      num = acc;
      // remainders come out least significant first
      do begin
        if (rems.size() < MAX_OUT_DIGITS_DEF) rems.push_back(int'(num % tr));
        else wrapped = 1'b1;
        num = num / tr;
      end while (num != '0);
      for (int k = rems.size() - 1; k >= 0; k--) begin
        w.out_char  = to_char(rems[k]);
        w.last_out  = (k == 0);
        w.overflow  = wrapped;
        w.bad_digit = skipped;
        expected_chars.push_back(w);
      end
      acc     = '0;
      wrapped = 1'b0;
      skipped = 1'b0;
    endfunction

    function void check_char(result_word_t got);
      result_word_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected word: char %h last %b ovf %b bad %b", $realtime,
                   got.out_char, got.last_out, got.overflow, got.bad_digit);
        return;
      end
      want = expected_chars.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] mismatch: exp char %h last %b ovf %b bad %b, got %h %b %b %b",
                   $realtime, want.out_char, want.last_out, want.overflow, want.bad_digit,
                   got.out_char, got.last_out, got.overflow, got.bad_digit);
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SOURCE_RADIX;
  logic [RADIX_W-1:0]   cfg_data  = '0;
  logic                 sink_rdy  = 1'b0;
  bit                   idle_on   = 1'b0;
  int unsigned          items_sent   = 0;
  int unsigned          hold_left    = 0;
  int unsigned          quiet_cycles = 0;

  conversion_checker chk = new();

  rdsc_in_if  in_ch ();
  rdsc_out_if out_ch ();

  assign out_ch.ready = sink_rdy;

  radix_digit_string_converter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      chk.check_char({out_ch.out_char, out_ch.last_out, out_ch.overflow, out_ch.bad_digit});
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      sink_rdy  <= (hold_left == 1);
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold_left <= $urandom_range(1, 8);
      sink_rdy  <= 1'b0;
    end else begin
      sink_rdy <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_word(logic [CHAR_W-1:0] c, logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.digit_char <= c;
    in_ch.last_digit <= fin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    chk.load_char(c, fin);
    if (items_sent >= CALM_AFTER) idle_on = 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    while (chk.expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radices(logic [RADIX_W-1:0] src, logic [RADIX_W-1:0] dst);
    in_ch.valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SOURCE_RADIX;
    cfg_data  <= src;
    @(posedge clk);
    chk.set_reg(REG_SOURCE_RADIX, src);
    cfg_index <= REG_TARGET_RADIX;
    cfg_data  <= dst;
    @(posedge clk);
    chk.set_reg(REG_TARGET_RADIX, dst);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RADIX_W-1:0] pick_radix();
    case ($urandom_range(0, 9))
      0: return RADIX_W'($urandom_range(0, 63));
      1: return $urandom_range(0, 1) ? RADIX_MIN : RADIX_MAX;
      default: return RADIX_W'($urandom_range(2, 36));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom_range(0, 255));
    return chk.to_char($urandom_range(0, chk.sat_radix(chk.src_reg) - 1));
  endfunction

  initial begin
    int unsigned len;
    in_ch.valid      = 1'b0;
    in_ch.digit_char = '0;
    in_ch.last_digit = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default radices 10 -> 16
    send_text("0");
    send_word(8'hFF, 1'b1);
    send_word("1", 1'b0);
    send_word("A", 1'b0);
    send_word(8'h00, 1'b1);
    send_text("4294967295");
    // base 36 wraps the accumulator; base 2 gives the longest result
    write_radices(RADIX_MAX, RADIX_MIN);
    send_text("ZZZZZZZ");
    // out-of-range register values saturate
    write_radices(6'd0, 6'd63);
    send_text("12");
    write_radices(6'd37, 6'd1);
    send_text("Z");

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) write_radices(pick_radix(), pick_radix());
      idle_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_word(pick_char(), i == len - 1);
    end
    idle_on = 1'b0;
    in_ch.valid <= 1'b0;
    wait_drained();

    if (chk.mismatches == 0 && chk.expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
